[hdl/md5_hash_core_macros.svh]
// Assertion helpers for the MD5 hash core.
// Every check samples on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef MD5_HASH_CORE_MACROS_SVH
`define MD5_HASH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MD5H_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MD5H_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/md5h_pkg.sv]
`timescale 1ns / 1ps

package md5h_pkg;

    localparam int BLK_WORDS = 16;
    localparam int ROUNDS    = 64;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] MARK_BYTE = 8'h80;
    localparam logic [2:0] BYTES_PER_WORD = 3'd4;

    // Word slots of a block that matter for padding, and the index of the last round.
    localparam logic [3:0] POS_LAST    = 4'(BLK_WORDS - 1);
    localparam logic [3:0] LEN_LO_POS  = 4'(BLK_WORDS - 2);
    localparam logic [3:0] LEN_HI_POS  = 4'(BLK_WORDS - 1);
    localparam logic [3:0] MARK_POS_MAX = 4'(BLK_WORDS - 3);
    localparam logic [5:0] RND_LAST    = 6'(ROUNDS - 1);

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        WSEL_INPUT,
        WSEL_MARK,
        WSEL_LEN_LO,
        WSEL_LEN_HI,
        WSEL_ZERO
    } t_wsel;

    typedef struct packed {
        logic        wr_en;
        t_wsel       wr_sel;
        logic [3:0]  wr_addr;
        logic        rnd_en;
        logic [5:0]  rnd;
        logic        acc_len;
        logic        add_chain;
        logic        restart;
        logic        load_out;
        logic        in_stall;
    } t_ctrl;

    // Message word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'((r4 << 2) + r4 + 4'd1);
            2'd2:    idx = 4'((r4 << 1) + r4 + 4'd5);
            default: idx = 4'((r4 << 3) - r4);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

[hdl/md5h_round.sv]
`timescale 1ns / 1ps

// One MD5 round; the sequencer feeds it once per cycle.
module md5h_round import md5h_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [5:0]  i_rnd,
    input  logic [31:0] i_msg,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);

    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [4:0]  w_shift;

    assign w_f     = round_f(i_rnd[5:4], i_b, i_c, i_d);
    assign w_sum   = i_a + w_f + ROUND_K[i_rnd] + i_msg;
    assign w_shift = ROUND_S[{i_rnd[5:4], i_rnd[1:0]}];

    assign o_a = i_d;
    assign o_b = i_b + rotl32(w_sum, w_shift);
    assign o_c = i_b;
    assign o_d = i_c;

endmodule

[hdl/md5h_msg_buf.sv]
`timescale 1ns / 1ps

// Sixteen-word block buffer: one write port, one read port.
module md5h_msg_buf import md5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_addr,
    input  logic [31:0] i_wr_data,
    input  logic [3:0]  i_rd_addr,
    output logic [31:0] o_rd_data
);

    logic [31:0] r_words [BLK_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_words[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_words[i_rd_addr];

endmodule

[hdl/md5h_seq.sv]
`timescale 1ns / 1ps

// Sequencer: word position, round counter and padding flags.
module md5h_seq import md5h_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_final,
    input  logic  i_full_word,
    input  logic  i_out_busy,
    output t_ctrl o_ctrl
);

    t_state     r_state, n_state;
    logic [3:0] r_pos, n_pos;
    logic [5:0] r_rnd, n_rnd;
    logic       r_fin, n_fin;
    logic       r_need_mark, n_need_mark;
    logic       r_last_blk, n_last_blk;
    logic       w_accept;
    logic       w_pos_last;

    assign w_accept   = (r_state == ST_IDLE) && i_valid;
    assign w_pos_last = (r_pos == POS_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_pos_last) begin
                        n_state = ST_COMP;
                    end else if (i_final) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (w_pos_last) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_rnd == RND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_last_blk) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // A block is the last when its end marker landed low enough to leave room for
    // the two length words, or when it follows a padded block that had no room for them.
    always_comb begin
        n_pos       = r_pos;
        n_rnd       = r_rnd;
        n_fin       = r_fin;
        n_need_mark = r_need_mark;
        n_last_blk  = r_last_blk;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pos       = r_pos + 4'd1;
                    n_fin       = i_final;
                    n_need_mark = i_final && i_full_word;
                    n_last_blk  = i_final && !i_full_word && (r_pos <= MARK_POS_MAX);
                end
            end
            ST_PAD: begin
                n_pos       = r_pos + 4'd1;
                n_need_mark = 1'b0;
                if (r_need_mark) begin
                    n_last_blk = (r_pos <= MARK_POS_MAX);
                end
            end
            ST_COMP: begin
                n_rnd = r_rnd + 6'd1;
            end
            ST_ADD: begin
                if (r_fin && !r_last_blk) begin
                    n_last_blk = 1'b1;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_fin = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.wr_sel   = WSEL_ZERO;
        o_ctrl.wr_addr  = r_pos;
        o_ctrl.rnd      = r_rnd;
        o_ctrl.in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_ctrl.wr_en   = i_valid;
                o_ctrl.wr_sel  = WSEL_INPUT;
                o_ctrl.acc_len = i_valid;
            end
            ST_PAD: begin
                o_ctrl.wr_en = 1'b1;
                if (r_need_mark) begin
                    o_ctrl.wr_sel = WSEL_MARK;
                end else if (r_last_blk && (r_pos == LEN_LO_POS)) begin
                    o_ctrl.wr_sel = WSEL_LEN_LO;
                end else if (r_last_blk && (r_pos == LEN_HI_POS)) begin
                    o_ctrl.wr_sel = WSEL_LEN_HI;
                end else begin
                    o_ctrl.wr_sel = WSEL_ZERO;
                end
            end
            ST_COMP: begin
                o_ctrl.rnd_en = 1'b1;
            end
            ST_ADD: begin
                o_ctrl.add_chain = 1'b1;
            end
            ST_DONE: begin
                o_ctrl.load_out = !i_out_busy;
                o_ctrl.restart  = !i_out_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_rnd       <= '0;
            r_fin       <= 1'b0;
            r_need_mark <= 1'b0;
            r_last_blk  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_rnd       <= n_rnd;
            r_fin       <= n_fin;
            r_need_mark <= n_need_mark;
            r_last_blk  <= n_last_blk;
        end
    end

endmodule

[hdl/md5_hash_core.sv]
`timescale 1ns / 1ps
//  Channel   Valid     Stall     Payload
//  input     i_valid   o_stall   i_data_word, i_valid_bytes, i_final_item
//  output    o_valid   i_stall   o_digest_half, o_last_half
//
//  Requests are taken while the core is idle; the sixteenth word of a block then
//  starts 64 rounds on the single round unit and an add step. A final request
//  adds one padding step per remaining slot of each padded block, one or two
//  compressions and a step to copy the digest out. o_stall is high while the
//  core works and while a new digest waits for the output register to empty;
//  i_stall holds the offered half. Reset is synchronous.
`include "md5_hash_core_macros.svh"

module md5_hash_core import md5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_half,
    output logic        o_last_half
);

    t_ctrl        w_ctrl;
    logic [31:0]  r_chain [4];
    logic [31:0]  r_wk_a, r_wk_b, r_wk_c, r_wk_d;
    logic [63:0]  r_bit_len;
    logic [127:0] r_digest;
    logic         r_out_valid;
    logic         r_out_last;

    logic [2:0]  w_vb_sat;
    logic        w_full_word;
    logic [31:0] w_in_word;
    logic [31:0] w_wr_data;
    logic [5:0]  w_len_inc;
    logic [31:0] w_msg;
    logic        w_first;
    logic [31:0] w_src_a, w_src_b, w_src_c, w_src_d;
    logic [31:0] w_rnd_a, w_rnd_b, w_rnd_c, w_rnd_d;
    logic        w_take_lo;
    logic        w_take_hi;
    logic [65:0] w_out_all;

    // Byte counts above four on a final request count as a full word.
    assign w_vb_sat    = (i_valid_bytes > BYTES_PER_WORD) ? BYTES_PER_WORD : i_valid_bytes;
    assign w_full_word = (w_vb_sat == BYTES_PER_WORD);

    // On a short final word the end marker goes right after the last message
    // byte and the unused high bytes are dropped.
    always_comb begin
        if (!i_final_item) begin
            w_in_word = i_data_word;
        end else begin
            case (w_vb_sat)
                3'd0:    w_in_word = {24'h0, MARK_BYTE};
                3'd1:    w_in_word = {16'h0, MARK_BYTE, i_data_word[7:0]};
                3'd2:    w_in_word = {8'h0, MARK_BYTE, i_data_word[15:0]};
                3'd3:    w_in_word = {MARK_BYTE, i_data_word[23:0]};
                default: w_in_word = i_data_word;
            endcase
        end
    end

    always_comb begin
        case (w_ctrl.wr_sel)
            WSEL_INPUT:  w_wr_data = w_in_word;
            WSEL_MARK:   w_wr_data = {24'h0, MARK_BYTE};
            WSEL_LEN_LO: w_wr_data = r_bit_len[31:0];
            WSEL_LEN_HI: w_wr_data = r_bit_len[63:32];
            default:     w_wr_data = '0;
        endcase
    end

    assign w_len_inc = i_final_item ? {w_vb_sat, 3'b000} : 6'd32;

    md5h_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_final     (i_final_item),
        .i_full_word (w_full_word),
        .i_out_busy  (r_out_valid),
        .o_ctrl      (w_ctrl)
    );

    md5h_msg_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_ctrl.wr_en),
        .i_wr_addr (w_ctrl.wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (msg_index(w_ctrl.rnd)),
        .o_rd_data (w_msg)
    );

    // Round zero starts from the chaining words; later rounds from the
    // working registers.
    assign w_first = (w_ctrl.rnd == '0);
    assign w_src_a = w_first ? r_chain[0] : r_wk_a;
    assign w_src_b = w_first ? r_chain[1] : r_wk_b;
    assign w_src_c = w_first ? r_chain[2] : r_wk_c;
    assign w_src_d = w_first ? r_chain[3] : r_wk_d;

    md5h_round u_round (
        .i_a   (w_src_a),
        .i_b   (w_src_b),
        .i_c   (w_src_c),
        .i_d   (w_src_d),
        .i_rnd (w_ctrl.rnd),
        .i_msg (w_msg),
        .o_a   (w_rnd_a),
        .o_b   (w_rnd_b),
        .o_c   (w_rnd_c),
        .o_d   (w_rnd_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctrl.rnd_en) begin
            r_wk_a <= w_rnd_a;
            r_wk_b <= w_rnd_b;
            r_wk_c <= w_rnd_c;
            r_wk_d <= w_rnd_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctrl.restart) begin
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
            r_bit_len  <= '0;
        end else begin
            if (w_ctrl.add_chain) begin
                r_chain[0] <= r_chain[0] + r_wk_a;
                r_chain[1] <= r_chain[1] + r_wk_b;
                r_chain[2] <= r_chain[2] + r_wk_c;
                r_chain[3] <= r_chain[3] + r_wk_d;
            end
            if (w_ctrl.acc_len) begin
                r_bit_len <= r_bit_len + 64'(w_len_inc);
            end
        end
    end

    // A finished digest moves into the output register in the same cycle as
    // the chaining words restart, so the next message can come in while the
    // digest waits. The sequencer loads it only when the register is empty.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_digest <= {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};
        end
    end

    // The low half goes out first, then the high half; a stall holds either.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= !r_out_last;
            r_out_last  <= !r_out_last;
        end
    end

    assign o_stall       = w_ctrl.in_stall;
    assign o_valid       = r_out_valid;
    assign o_last_half   = r_out_last;
    assign o_digest_half = r_out_last ? r_digest[127:64] : r_digest[63:0];

    assign w_take_lo = o_valid && !o_last_half && !i_stall;
    assign w_take_hi = o_valid && o_last_half && !i_stall;
    assign w_out_all = {o_valid, o_last_half, o_digest_half};

    // A new digest never overwrites one that is still on offer.
    `MD5H_ASSERT_SAME(a_load_empty, w_ctrl.load_out, !o_valid, "digest loaded over a waiting one")
    // The low half is always followed directly by the high half.
    `MD5H_ASSERT_NEXT(a_hi_after_lo, w_take_lo, o_valid && o_last_half, "high half missing")
    // Once the high half is taken the output register is empty.
    `MD5H_ASSERT_NEXT(a_empty_after_hi, w_take_hi, !o_valid, "output register not emptied")
    // A stalled half stays exactly as it is.
    `MD5H_ASSERT_NEXT(a_half_held, o_valid && i_stall, $stable(w_out_all), "stalled half moved")

endmodule

[sim/md5_hash_core_test.sv]
`timescale 1ns / 1ps

module md5_hash_core_test;
    import md5h_pkg::*;

    // A digest request that finishes a message yields two halves. Each expected
    // half is held in arrival order until the core hands it out.
    typedef struct packed {
        logic [63:0] half;
        logic        last;
    } digest_half_t;

    // The longest stretch without any handshake that a correct run can show is
    // the deliberate receiver hold-off, so the watchdog limit sits well above it.
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int TARGET_ITEMS  = 750;
    localparam int REPORT_MAX    = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_data_word;
    logic [2:0]  i_valid_bytes;
    logic        i_final_item;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_digest_half;
    logic        o_last_half;

    md5_hash_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_final_item  (i_final_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_half (o_digest_half),
        .o_last_half   (o_last_half)
    );

    // Predictor state: the chaining words, the partly filled 64-byte block, the
    // next free word slot and the running message length in bits.
    logic [31:0]  chain [4];
    logic [31:0]  msg_block [16];
    int           fill_pos;
    logic [63:0]  msg_bits;

    digest_half_t pending_digest [$];

    int error_count;
    int items_sent;
    int long_hold_cycles;
    bit tx_idle;
    bit rx_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Only the first few mismatches are described; the rest are just counted.
    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Back to the MD5 initial chaining values with an empty message.
    function automatic void md5_restart();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        fill_pos = 0;
        msg_bits = 64'd0;
    endfunction

    // One full MD5 compression of msg_block into the chaining words.
    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, sum, nb;
        logic [3:0]  m;
        logic [4:0]  sh;
        int          r;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = d ^ (b & (c ^ d));
                    m = 4'(r);
                end
                1: begin
                    f = c ^ (d & (b ^ c));
                    m = 4'(5 * r + 1);
                end
                2: begin
                    f = b ^ c ^ d;
                    m = 4'(3 * r + 5);
                end
                default: begin
                    f = c ^ (b | ~d);
                    m = 4'(7 * r);
                end
            endcase
            sh  = ROUND_S[(r / 16) * 4 + r % 4];
            sum = a + f + ROUND_K[r] + msg_block[m];
            nb  = b + ((sum << sh) | (sum >> (32 - sh)));
            a = d;
            d = c;
            c = b;
            b = nb;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endfunction

    // Puts one word into the block and compresses once the block is full.
    function automatic void store_word(input logic [31:0] word);
        msg_block[fill_pos] = word;
        fill_pos++;
        if (fill_pos == 16) begin
            md5_compress();
            fill_pos = 0;
        end
    endfunction

    // Advances the predictor by one accepted request. A final request pads the
    // message, appends the bit length and queues both digest halves.
    function automatic void md5_absorb(input logic [31:0] word, input logic [2:0] vb,
                                       input logic fin);
        logic [2:0]  nbytes;
        logic [31:0] keep;
        if (!fin) begin
            msg_bits = msg_bits + 64'd32;
            store_word(word);
            return;
        end
        // Byte counts above a full word saturate to four.
        nbytes   = (vb > BYTES_PER_WORD) ? BYTES_PER_WORD : vb;
        msg_bits = msg_bits + 64'(8 * nbytes);
        if (nbytes < BYTES_PER_WORD) begin
            // Unused high bytes are dropped and the marker byte takes the first
            // free byte lane of the same word.
            keep = (32'd1 << (8 * nbytes)) - 32'd1;
            msg_block[fill_pos] = (word & keep) | (32'(MARK_BYTE) << (8 * nbytes));
            fill_pos++;
        end else begin
            store_word(word);
            msg_block[fill_pos] = 32'(MARK_BYTE);
            fill_pos++;
        end
        // No room left for the length: pad out this block and start another.
        if (fill_pos > 14) begin
            while (fill_pos < 16) begin
                msg_block[fill_pos] = 32'd0;
                fill_pos++;
            end
            md5_compress();
            fill_pos = 0;
        end
        while (fill_pos < 14) begin
            msg_block[fill_pos] = 32'd0;
            fill_pos++;
        end
        msg_block[14] = msg_bits[31:0];
        msg_block[15] = msg_bits[63:32];
        md5_compress();
        pending_digest.push_back('{half: {chain[1], chain[0]}, last: 1'b0});
        pending_digest.push_back('{half: {chain[3], chain[2]}, last: 1'b1});
        md5_restart();
    endfunction

    // Offers one request after a random gap and waits for it to be taken. The
    // payload stays put while the core stalls; prediction happens on acceptance.
    task automatic send_request(input logic [31:0] word, input logic [2:0] vb,
                                input logic fin);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_word   <= word;
        i_valid_bytes <= vb;
        i_final_item  <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        md5_absorb(word, vb, fin);
        items_sent++;
    endtask

    // A message of full words with random content, closed by a final request.
    // The byte count on the full words is random since the core ignores it there.
    task automatic send_message(input int n_words, input logic [2:0] last_vb);
        int k;
        for (k = 0; k < n_words; k++)
            send_request($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_request($urandom, last_vb, 1'b1);
    endtask

    // Short messages that cover every byte count on the final request, the empty
    // message, saturation of counts above four, dropped high bytes and the
    // all-zero and all-one data words.
    task automatic test_directed_cases();
        send_request(32'hffff_ffff, 3'd0, 1'b1);
        send_request(32'hff63_6261, 3'd3, 1'b1);
        send_request(32'h0000_0000, 3'd4, 1'b1);
        send_request(32'hffff_ffff, 3'd7, 1'b1);
        send_request(32'h0000_0000, 3'd5, 1'b0);
        send_request(32'hffff_ffff, 3'd0, 1'b0);
        send_request(32'h1234_5678, 3'd6, 1'b1);
        send_request(32'hffff_ffff, 3'd1, 1'b1);
        send_request(32'hffff_ffff, 3'd2, 1'b1);
        send_request(32'hffff_ffff, 3'd4, 1'b1);
        send_request(32'h0000_0000, 3'd1, 1'b1);
        send_request(32'haaaa_5555, 3'd5, 1'b1);
        send_request(32'h5555_aaaa, 3'd7, 1'b0);
        send_request(32'hffff_ffff, 3'd3, 1'b1);
    endtask

    // Messages whose end lands around the block edge: the marker and the length
    // fitting, the length spilling into a second block, and the final word
    // itself completing a block before the marker.
    task automatic test_block_boundaries();
        int nw;
        for (nw = 12; nw <= 16; nw++) begin
            send_message(nw, 3'd0);
            send_message(nw, 3'd3);
            send_message(nw, 3'd4);
        end
        send_message(29, 3'd4);
        send_message(30, 3'd3);
        send_message(31, 3'd4);
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so
    // the core has to sit on a finished digest and stall its input.
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        long_hold_cycles = HOLD_CYCLES;
        send_message(0, 3'd2);
        send_message(3, 3'd4);
        send_message(16, 3'd0);
        send_message(2, 3'd7);
        tx_idle = 1'b1;
    endtask

    // Random messages, mostly within one block and now and then a few blocks
    // long. Idling on each side is switched per message so that stretches with
    // no gaps at all occur as well.
    task automatic test_random_messages();
        int n_words;
        int mode;
        while (items_sent < TARGET_ITEMS) begin
            mode    = $urandom_range(0, 3);
            tx_idle = (mode == 1 || mode == 3);
            rx_idle = (mode == 2 || mode == 3);
            if ($urandom_range(0, 7) == 0)
                n_words = $urandom_range(17, 40);
            else
                n_words = $urandom_range(0, 16);
            send_message(n_words, 3'($urandom_range(0, 7)));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver: for each digest half a random number of stall cycles, counted
    // while a half is on offer. A long hold-off request overrides this.
    initial begin : rx_side
        int unsigned hold_cnt;
        hold_cnt = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (long_hold_cycles) @(posedge i_clk);
                long_hold_cycles = 0;
                hold_cnt = 0;
            end else begin
                if (o_valid && !i_stall)
                    hold_cnt = rx_idle ? $urandom_range(0, 15) : 0;
                else if (o_valid && hold_cnt > 0)
                    hold_cnt--;
                i_stall <= (hold_cnt > 0);
            end
        end
    end

    // Every digest half taken from the core is compared with the oldest one
    // predicted, field by field.
    always @(posedge i_clk) begin
        digest_half_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest.size() == 0) begin
                flag_error($sformatf("unexpected digest half %h last %b",
                                     o_digest_half, o_last_half));
            end else begin
                want = pending_digest.pop_front();
                if (o_digest_half !== want.half)
                    flag_error($sformatf("digest half: expected %h, got %h",
                                         want.half, o_digest_half));
                if (o_last_half !== want.last)
                    flag_error($sformatf("last half flag: expected %b, got %b",
                                         want.last, o_last_half));
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means the
    // core has hung.
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("TIMEOUT: no handshake for %0d cycles", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        error_count      = 0;
        items_sent       = 0;
        long_hold_cycles = 0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        md5_restart();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data_word   <= 32'd0;
        i_valid_bytes <= 3'd0;
        i_final_item  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_block_boundaries();
        test_output_backpressure();
        test_random_messages();

        // Let the last digest come out, then watch a while for stray results.
        i_valid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_digest.size() != 0)
            flag_error($sformatf("%0d digest halves never arrived",
                                 pending_digest.size()));

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
